// ===== rtl/rtcfc_pkg.sv =====
// package: register indexes, command codes and conversion helpers for the rtc time format converter
`timescale 1ns / 1ps
`default_nettype none

package rtcfc_pkg;

  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_ENCODE = 1'b1;

  localparam logic REG_BCD_MODE     = 1'b0;
  localparam logic REG_HOUR_24_MODE = 1'b1;

  localparam logic [7:0] PM_FLAG      = 8'h80;
  localparam logic [7:0] HOUR_MASK    = 8'h7F;
  localparam logic [7:0] CENTURY_LOW  = 8'd19;
  localparam logic [7:0] CENTURY_HIGH = 8'd21;
  localparam logic [7:0] CENTURY_DEF  = 8'd20;
  localparam logic [4:0] HOURS_HALF   = 5'd12;

  // low nibble plus ten times high nibble, digits not checked
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    from_bcd = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
  endfunction

  // quotient by ten through reciprocal 205/2048, exact for 8-bit values
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [18:0] p;
    logic [4:0]  q;
    logic [7:0]  q10;
    logic [7:0]  d;
    p   = {11'd0, v} * 19'd205;
    q   = p[15:11];
    q10 = {q, 3'b000} + {2'b00, q, 1'b0};
    d   = v - q10;
    to_bcd = {q[3:0], d[3:0]};
  endfunction

  // remainder by twelve through reciprocal 171/2048, exact for 8-bit values
  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [18:0] p;
    logic [4:0]  q;
    logic [7:0]  q12;
    logic [7:0]  d;
    p   = {11'd0, v} * 19'd171;
    q   = p[15:11];
    q12 = {q, 3'b000} + {1'b0, q, 2'b00};
    d   = v - q12;
    mod12 = d[3:0];
  endfunction

  // quotient by one hundred through reciprocal 5243/2^19, exact for 14-bit values
  function automatic logic [7:0] div100(input logic [13:0] v);
    logic [27:0] p;
    p = {14'd0, v} * 28'd5243;
    div100 = p[26:19];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rtc_time_format_converter.sv =====
// top level: rtc register byte decode and encode with bcd and 12-hour options
// one input register and one result register, with a single conversion stage between them
// throughput: one transaction per cycle while out_ready is high
// each stage holds while the next is stalled, so a waiting result stalls input once s1 is full
// reset: synchronous active high, clears both valid flags, sets bcd_mode and hour_24_mode to 1
`timescale 1ns / 1ps
`default_nettype none

module rtc_time_format_converter (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write,
  input  wire         cfg_index,
  input  wire         cfg_data,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         cmd,
  input  wire  [7:0]  seconds_in,
  input  wire  [7:0]  minutes_in,
  input  wire  [7:0]  hours_in,
  input  wire  [7:0]  day_in,
  input  wire  [7:0]  month_in,
  input  wire  [13:0] year_in,
  input  wire  [7:0]  century_in,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  seconds_out,
  output logic [7:0]  minutes_out,
  output logic [7:0]  hours_out,
  output logic [7:0]  day_out,
  output logic [7:0]  month_out,
  output logic [11:0] year_out,
  output logic [7:0]  century_out,
  output logic        time_valid
);
  import rtcfc_pkg::*;

  logic        bcd_mode;
  logic        hour_24_mode;

  logic        s1_valid;
  logic        s1_cmd;
  logic [7:0]  s1_sec;
  logic [7:0]  s1_min;
  logic [7:0]  s1_hour;
  logic [7:0]  s1_day;
  logic [7:0]  s1_mon;
  logic [13:0] s1_year;
  logic [7:0]  s1_cent;

  logic        s2_ready;

  logic [7:0]  seconds_next;
  logic [7:0]  minutes_next;
  logic [7:0]  hours_next;
  logic [7:0]  day_next;
  logic [7:0]  month_next;
  logic [11:0] year_next;
  logic [7:0]  century_next;
  logic        time_valid_next;

  // decode terms
  logic        dec_pm;
  logic [7:0]  dec_sec;
  logic [7:0]  dec_min;
  logic [7:0]  dec_hour_raw;
  logic [7:0]  dec_hour;
  logic [7:0]  dec_day;
  logic [7:0]  dec_mon;
  logic [7:0]  dec_yb;
  logic [7:0]  dec_cent_raw;
  logic [7:0]  dec_cent;
  logic [11:0] dec_full;
  logic        dec_ok;

  // encode terms
  logic [7:0]  enc_cent;
  logic [6:0]  enc_yr;
  logic [13:0] enc_cent100;
  logic [13:0] enc_rem;
  logic [3:0]  enc_h12;
  logic [7:0]  enc_h12b;
  logic [7:0]  enc_hb;

  assign s2_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcd_mode     <= 1'b1;
      hour_24_mode <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BCD_MODE:     bcd_mode     <= cfg_data;
        REG_HOUR_24_MODE: hour_24_mode <= cfg_data;
        default:          bcd_mode     <= bcd_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd  <= cmd;
      s1_sec  <= seconds_in;
      s1_min  <= minutes_in;
      s1_hour <= hours_in;
      s1_day  <= day_in;
      s1_mon  <= month_in;
      s1_year <= year_in;
      s1_cent <= century_in;
    end
  end

  always_comb begin
    dec_pm       = !hour_24_mode && ((s1_hour & PM_FLAG) != 8'd0);
    dec_hour_raw = s1_hour & HOUR_MASK;
    dec_yb       = s1_year[7:0];
    dec_cent_raw = s1_cent;
    dec_sec      = s1_sec;
    dec_min      = s1_min;
    dec_day      = s1_day;
    dec_mon      = s1_mon;
    if (bcd_mode) begin
      dec_sec      = from_bcd(s1_sec);
      dec_min      = from_bcd(s1_min);
      dec_hour_raw = from_bcd(s1_hour & HOUR_MASK);
      dec_day      = from_bcd(s1_day);
      dec_mon      = from_bcd(s1_mon);
      dec_yb       = from_bcd(s1_year[7:0]);
      dec_cent_raw = from_bcd(s1_cent);
    end
    dec_hour = dec_hour_raw;
    if (!hour_24_mode) begin
      dec_hour = {4'd0, mod12(dec_hour_raw)} + (dec_pm ? {3'd0, HOURS_HALF} : 8'd0);
    end
    dec_cent = dec_cent_raw;
    if (dec_cent_raw < CENTURY_LOW || dec_cent_raw > CENTURY_HIGH) begin
      dec_cent = CENTURY_DEF;
    end
    dec_full = ({4'd0, dec_cent} * 12'd100) + {4'd0, dec_yb};
    dec_ok   = (dec_mon >= 8'd1) && (dec_mon <= 8'd12) && (dec_day >= 8'd1) &&
               (dec_day <= 8'd31) && (dec_hour < 8'd24) && (dec_min < 8'd60) &&
               (dec_sec < 8'd60);
  end

  always_comb begin
    enc_cent    = div100(s1_year);
    enc_cent100 = {6'd0, enc_cent} * 14'd100;
    enc_rem     = s1_year - enc_cent100;
    enc_yr      = enc_rem[6:0];
    enc_h12     = mod12(s1_hour);
    enc_h12b    = (enc_h12 == 4'd0) ? {3'd0, HOURS_HALF} : {4'd0, enc_h12};
    if (bcd_mode) begin
      enc_h12b = to_bcd(enc_h12b);
    end
    if (hour_24_mode) begin
      enc_hb = bcd_mode ? to_bcd(s1_hour) : s1_hour;
    end else begin
      enc_hb = enc_h12b | ((s1_hour >= {3'd0, HOURS_HALF}) ? PM_FLAG : 8'd0);
    end
  end

  always_comb begin
    case (s1_cmd)
      CMD_DECODE: begin
        seconds_next    = dec_sec;
        minutes_next    = dec_min;
        hours_next      = dec_hour;
        day_next        = dec_day;
        month_next      = dec_mon;
        year_next       = dec_full;
        century_next    = 8'd0;
        time_valid_next = dec_ok;
      end
      CMD_ENCODE: begin
        seconds_next    = bcd_mode ? to_bcd(s1_sec) : s1_sec;
        minutes_next    = bcd_mode ? to_bcd(s1_min) : s1_min;
        hours_next      = enc_hb;
        day_next        = bcd_mode ? to_bcd(s1_day) : s1_day;
        month_next      = bcd_mode ? to_bcd(s1_mon) : s1_mon;
        year_next       = {4'd0, (bcd_mode ? to_bcd({1'b0, enc_yr}) : {1'b0, enc_yr})};
        century_next    = bcd_mode ? to_bcd(enc_cent) : enc_cent;
        time_valid_next = 1'b1;
      end
      default: begin
        seconds_next    = 8'd0;
        minutes_next    = 8'd0;
        hours_next      = 8'd0;
        day_next        = 8'd0;
        month_next      = 8'd0;
        year_next       = 12'd0;
        century_next    = 8'd0;
        time_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      seconds_out <= seconds_next;
      minutes_out <= minutes_next;
      hours_out   <= hours_next;
      day_out     <= day_next;
      month_out   <= month_next;
      year_out    <= year_next;
      century_out <= century_next;
      time_valid  <= time_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted transaction not held in input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_cmd) && $stable(s1_year))
    else $error("input register changed while stalled");

  a_encode_valid: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && (s1_cmd == CMD_ENCODE) |=> out_valid && time_valid)
    else $error("encode result without time_valid");

  a_decode_century: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready && (s1_cmd == CMD_DECODE)
    |=> out_valid && (century_out == 8'd0) && (year_out >= 12'd1900))
    else $error("decode result with bad century or year");
`endif

endmodule

`default_nettype wire
